// File: hdl/cpf_pkg.sv
// Package for the CRC-16 packet framer.
// Holds the function and transfer-kind codes, the held item type and the CRC byte fold.
// No dependencies.
`timescale 1ns / 1ps

package cpf_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned HDR_BYTES = 7;
  localparam int unsigned IDX_W     = $clog2(HDR_BYTES);

  // Configuration register indexes
  localparam logic [0:0] CFG_SYNC_ONE = 1'b0;
  localparam logic [0:0] CFG_SYNC_TWO = 1'b1;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_PAYLOAD = 2'd1,
    FUNC_FINISH  = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_MESSAGE = 2'd0,
    KIND_ANON    = 2'd1,
    KIND_SERVICE = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef struct packed {
    func_e       func;
    kind_e       kind;
    logic [6:0]  source_node;
    logic [6:0]  dest_node;
    logic [15:0] type_id;
    logic [10:0] payload_length;
    logic [4:0]  priority_level;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic last;       // final byte of the held item
    logic frame_end;  // high CRC byte
  } byte_ctl_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/cpf_byte_gen.sv
// Byte generator for the CRC-16 packet framer.
// Picks the frame byte for the held item and byte index, and computes the next CRC.
// Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_byte_gen import cpf_pkg::*; (
  input  item_t            item_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [15:0]      crc_i,
  input  logic [7:0]       sync_one_i,
  input  logic [7:0]       sync_two_i,
  output logic [7:0]       byte_o,
  output byte_ctl_t        ctl_o,
  output logic [15:0]      crc_o
);

  logic [7:0]  hdr_byte;
  logic [15:0] crc_base;

  // Header bytes by position and transfer kind
  always_comb begin
    hdr_byte = 8'h00;
    case (idx_i)
      3'd0: hdr_byte = sync_one_i;
      3'd1: hdr_byte = sync_two_i;
      3'd2: hdr_byte = {(item_i.kind == KIND_SERVICE), item_i.source_node};
      3'd3: begin
        case (item_i.kind)
          KIND_MESSAGE: hdr_byte = item_i.type_id[7:0];
          KIND_ANON:    hdr_byte = {6'b000000, item_i.type_id[1:0]};
          KIND_SERVICE: hdr_byte = {1'b1, item_i.dest_node};
          default:      hdr_byte = 8'h00;
        endcase
      end
      3'd4: begin
        case (item_i.kind)
          KIND_MESSAGE: hdr_byte = item_i.type_id[15:8];
          KIND_SERVICE: hdr_byte = item_i.type_id[7:0];
          default:      hdr_byte = 8'h00;
        endcase
      end
      3'd5: hdr_byte = {item_i.payload_length[10:8], item_i.priority_level};
      3'd6: hdr_byte = item_i.payload_length[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // Restart the CRC on the first header byte
  assign crc_base = (idx_i == '0) ? CRC_INIT : crc_i;

  always_comb begin
    byte_o = 8'h00;
    ctl_o  = '{last: 1'b1, frame_end: 1'b0};
    crc_o  = crc_i;
    case (item_i.func)
      FUNC_START: begin
        byte_o         = hdr_byte;
        ctl_o.last     = (idx_i == IDX_W'(HDR_BYTES - 1));
        crc_o          = crc_fold(crc_base, hdr_byte);
      end
      FUNC_PAYLOAD: begin
        byte_o = item_i.payload_byte;
        crc_o  = crc_fold(crc_i, item_i.payload_byte);
      end
      FUNC_FINISH: begin
        if (idx_i == '0) begin
          byte_o     = crc_i[7:0];
          ctl_o.last = 1'b0;
        end else begin
          byte_o          = crc_i[15:8];
          ctl_o.frame_end = 1'b1;
          crc_o           = CRC_INIT;
        end
      end
      default: begin
        byte_o = 8'h00;
      end
    endcase
  end

endmodule

// File: hdl/crc16_packet_framer.sv
// Top level of the CRC-16 packet framer.
// Item slot, byte sequencer, CRC register and output register; uses cpf_pkg and cpf_byte_gen.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------------------
//   in       | in  | in_valid_i / in_stall_o | func_i .. payload_byte_i (one command item)
//   out      | out | out_valid_o/ out_stall_i| out_byte_o, frame_end_o (one frame byte)
//   cfg      | in  | cfg_we_i                | cfg_idx_i, cfg_data_i (sync bytes)
//
// Output: one byte per cycle while the output is not stalled; a payload item makes one byte,
//   a finish item two and a start item seven; payload items stream back to back.
// Dropped items (unknown function, unknown transfer kind on start) are accepted but
//   never occupy the item slot.
// Reset: CRC at 0xFFFF, both sync bytes at zero, item slot and output register empty.
// Stalls: a stalled output byte holds in the output register, the held item waits in its
//   slot, and the input stalls until the item's last byte moves into the output register.
`timescale 1ns / 1ps

module crc16_packet_framer import cpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  transfer_kind_i,
  input  logic [6:0]  source_node_i,
  input  logic [6:0]  dest_node_i,
  input  logic [15:0] type_id_i,
  input  logic [10:0] payload_length_i,
  input  logic [4:0]  priority_level_i,
  input  logic [7:0]  payload_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  logic [7:0]       sync_one_q, sync_two_q;
  logic [15:0]      crc_q;
  item_t            item_q;
  logic             hold_valid_q, hold_valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             frame_end_q;

  logic [7:0]       gen_byte;
  byte_ctl_t        gen_ctl;
  logic [15:0]      gen_crc;

  logic             out_ready, emit, item_done, in_acc, keep_item;
  func_e            in_func;
  kind_e            in_kind;

  // Take a sync byte write at every edge with the write enable high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_one_q <= 8'h00;
      sync_two_q <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_ONE: sync_one_q <= cfg_data_i;
        CFG_SYNC_TWO: sync_two_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_func = func_e'(func_i);
  assign in_kind = kind_e'(transfer_kind_i);

  // Output register frees when empty or when its byte is taken
  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = hold_valid_q && out_ready;
  assign item_done = emit && gen_ctl.last;

  assign in_stall_o = hold_valid_q && !item_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Drop items that produce no bytes right at the input
  assign keep_item = (in_func != FUNC_RSVD) &&
                     !((in_func == FUNC_START) && (in_kind == KIND_RSVD));

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_acc) begin
      hold_valid_d = keep_item;
    end else if (item_done) begin
      hold_valid_d = 1'b0;
    end
  end

  // Advance through the bytes of the held item, rewind on its last one
  always_comb begin
    idx_d = idx_q;
    if (item_done || !hold_valid_q) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + 1'b1;
    end
  end

  cpf_byte_gen u_byte_gen (
    .item_i     (item_q),
    .idx_i      (idx_q),
    .crc_i      (crc_q),
    .sync_one_i (sync_one_q),
    .sync_two_i (sync_two_q),
    .byte_o     (gen_byte),
    .ctl_o      (gen_ctl),
    .crc_o      (gen_crc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      idx_q        <= '0;
      crc_q        <= CRC_INIT;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      idx_q        <= idx_d;
      if (emit) begin
        crc_q <= gen_crc;
      end
      if (out_ready) begin
        out_valid_q <= emit;
      end
    end
  end

  // Item payload and output byte registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.func           <= in_func;
      item_q.kind           <= in_kind;
      item_q.source_node    <= source_node_i;
      item_q.dest_node      <= dest_node_i;
      item_q.type_id        <= type_id_i;
      item_q.payload_length <= payload_length_i;
      item_q.priority_level <= priority_level_i;
      item_q.payload_byte   <= payload_byte_i;
    end
    if (emit) begin
      out_byte_q  <= gen_byte;
      frame_end_q <= gen_ctl.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

  // An empty slot always sits at the first byte
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_valid_q |-> (idx_q == '0))
    else $error("byte index off zero with empty item slot");

  // The byte index never runs past the header
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> (idx_q <= IDX_W'(HDR_BYTES - 1)))
    else $error("byte index beyond header length");

  // A kept item begins at its first byte
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && keep_item) |=> (hold_valid_q && (idx_q == '0)))
    else $error("accepted item not loaded at first byte");

  // The high CRC byte restarts the CRC
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && gen_ctl.frame_end) |=> (crc_q == CRC_INIT))
    else $error("CRC not restarted after frame end");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the CRC-16 packet framer.
// Holds the frame byte scoreboard, the command and byte-side drivers and the run sequence;
// depends on cpf_pkg and crc16_packet_framer.
`timescale 1ns / 1ps

module testbench import cpf_pkg::*; ();

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_GEN  = 16'h1021;
  localparam int unsigned ITEMS_PER_PHASE = 20;

  // One byte on the line as the framer should send it
  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
  } line_byte_t;

  // Scoreboard: predicts the frame bytes of each accepted command item and checks every
  // byte that leaves the block against the oldest outstanding prediction.
  class frame_byte_board;
    line_byte_t  due_q[$];
    logic [7:0]  sync_one;
    logic [7:0]  sync_two;
    logic [15:0] crc;
    int          errors;
    int          bytes_checked;
    int          frames_closed;

    function new();
      sync_one      = 8'h00;
      sync_two      = 8'h00;
      crc           = CRC_SEED;
      errors        = 0;
      bytes_checked = 0;
      frames_closed = 0;
    endfunction

    function void set_sync(logic [0:0] idx, logic [7:0] value);
      if (idx == CFG_SYNC_ONE) sync_one = value;
      else                     sync_two = value;
    endfunction

    // Bit-serial CRC-16/CCITT update, MSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
      end
      return c;
    endfunction

    function void queue_byte(logic [7:0] value, logic frame_end);
      line_byte_t lb;
      lb.value     = value;
      lb.frame_end = frame_end;
      due_q.push_back(lb);
    endfunction

    function void predict_frame_bytes(item_t it);
      logic [7:0] hdr[7];
      case (it.func)
        FUNC_START: begin
          if (it.kind != KIND_RSVD) begin
            hdr[0] = sync_one;
            hdr[1] = sync_two;
            case (it.kind)
              KIND_MESSAGE: begin
                hdr[2] = {1'b0, it.source_node};
                hdr[3] = it.type_id[7:0];
                hdr[4] = it.type_id[15:8];
              end
              KIND_ANON: begin
                hdr[2] = {1'b0, it.source_node};
                hdr[3] = {6'd0, it.type_id[1:0]};
                hdr[4] = 8'h00;
              end
              default: begin
                hdr[2] = {1'b1, it.source_node};
                hdr[3] = {1'b1, it.dest_node};
                hdr[4] = it.type_id[7:0];
              end
            endcase
            hdr[5] = {it.payload_length[10:8], it.priority_level};
            hdr[6] = it.payload_length[7:0];
            crc = CRC_SEED;
            for (int k = 0; k < 7; k++) begin
              queue_byte(hdr[k], 1'b0);
              crc = crc_step(crc, hdr[k]);
            end
          end
        end
        FUNC_PAYLOAD: begin
          queue_byte(it.payload_byte, 1'b0);
          crc = crc_step(crc, it.payload_byte);
        end
        FUNC_FINISH: begin
          queue_byte(crc[7:0], 1'b0);
          queue_byte(crc[15:8], 1'b1);
          crc = CRC_SEED;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < 20) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] value, logic frame_end);
      line_byte_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected byte %02h frame_end %0b", value, frame_end));
      end else begin
        want = due_q.pop_front();
        if (value !== want.value)
          report($sformatf("out_byte %02h, want %02h", value, want.value));
        if (frame_end !== want.frame_end)
          report($sformatf("frame_end %0b, want %0b", frame_end, want.frame_end));
        if (want.frame_end) frames_closed++;
      end
      bytes_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall_o;
  item_t       cmd;
  logic        out_valid_o;
  logic        out_stall;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;

  frame_byte_board board;
  logic            no_idle;
  int              items_in;
  int              settings_used;

  crc16_packet_framer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .func_i           (cmd.func),
    .transfer_kind_i  (cmd.kind),
    .source_node_i    (cmd.source_node),
    .dest_node_i      (cmd.dest_node),
    .type_id_i        (cmd.type_id),
    .payload_length_i (cmd.payload_length),
    .priority_level_i (cmd.priority_level),
    .payload_byte_i   (cmd.payload_byte),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte_o),
    .frame_end_o      (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d bytes still expected", board.due_q.size());
    $display("simulation failed");
    $finish;
  end

  // Random wait before the next item or byte; a burst (no_idle set) has no wait
  function automatic int draw_wait();
    if (no_idle) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic item_t make_item(func_e f, kind_e k, logic [6:0] src, logic [6:0] dst,
                                      logic [15:0] tid, logic [10:0] len, logic [4:0] pri,
                                      logic [7:0] pay);
    item_t it;
    it.func           = f;
    it.kind           = k;
    it.source_node    = src;
    it.dest_node      = dst;
    it.type_id        = tid;
    it.payload_length = len;
    it.priority_level = pri;
    it.payload_byte   = pay;
    return it;
  endfunction

  // Random content in every field, including the ones this function ignores
  function automatic item_t random_item(func_e f, kind_e k);
    return make_item(f, k, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                     16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2047)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endfunction

  // Offer one item after a random gap, hold it until accepted, then hand it to the board
  task send_item(input item_t it);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd      = it;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.predict_frame_bytes(it);
    // dropped and ignored items do not count as stimulus
    if (!(it.func == FUNC_RSVD || (it.func == FUNC_START && it.kind == KIND_RSVD)))
      items_in++;
  endtask

  // Drop valid and wait until every predicted byte has left the block, then let any
  // dropped item still in flight settle
  task wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task write_sync(input logic [0:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    board.set_sync(idx, value);
  endtask

  // Mostly well-formed frames with random contents; the rest is single noise items:
  // stray payloads and finishes, unknown functions, unknown kinds, restarts mid-frame
  task send_frame();
    int n;
    no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 6) != 0) begin
      send_item(random_item(FUNC_START, kind_e'($urandom_range(0, 2))));
      n = $urandom_range(0, 6);
      repeat (n) send_item(random_item(FUNC_PAYLOAD, kind_e'($urandom_range(0, 3))));
      send_item(random_item(FUNC_FINISH, kind_e'($urandom_range(0, 3))));
    end else begin
      send_item(random_item(func_e'($urandom_range(0, 3)), kind_e'($urandom_range(0, 3))));
    end
  endtask

  // Byte side: stall a random number of cycles, then take the next byte and check it
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_wait();
      if (n != 0) begin
        @(negedge clk_i);
        out_stall = 1'b1;
        repeat (n) @(posedge clk_i);
      end
      @(negedge clk_i);
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_byte(out_byte_o, frame_end_o);
    end
  end

  initial begin
    logic [15:0] sync_plan[5];
    int          target;
    board         = new();
    no_idle       = 1'b0;
    items_in      = 0;
    settings_used = 1;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SYNC_ONE;
    cfg_data      = 8'h00;
    in_valid      = 1'b0;
    cmd           = make_item(FUNC_START, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'd0);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, sync bytes at their reset value.
    // Payload and finish before any start: CRC runs from the reset seed.
    send_item(make_item(FUNC_PAYLOAD, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'hA5));
    send_item(make_item(FUNC_FINISH, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    // A bare finish right after a finish sends the seed itself
    send_item(make_item(FUNC_FINISH, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    // Message frame, all header fields at zero, payload extremes
    send_item(make_item(FUNC_START, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    send_item(make_item(FUNC_PAYLOAD, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    send_item(make_item(FUNC_PAYLOAD, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'hFF));
    send_item(make_item(FUNC_FINISH, KIND_MESSAGE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    // Message frame, all header fields at their maximum
    send_item(make_item(FUNC_START, KIND_MESSAGE, 7'd127, 7'd127, 16'hFFFF, 11'd2047, 5'd31,
                        8'hFF));
    send_item(make_item(FUNC_FINISH, KIND_MESSAGE, 7'd127, 7'd127, 16'hFFFF, 11'd2047, 5'd31,
                        8'hFF));
    // Anonymous frame: type id keeps two bits only
    send_item(make_item(FUNC_START, KIND_ANON, 7'd85, 7'd42, 16'hFFFF, 11'h5A3, 5'd21, 8'h00));
    send_item(make_item(FUNC_PAYLOAD, KIND_ANON, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h3C));
    send_item(make_item(FUNC_FINISH, KIND_ANON, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    // Service frames: bit 7 forced on source and destination
    send_item(make_item(FUNC_START, KIND_SERVICE, 7'd0, 7'd0, 16'h1234, 11'd0, 5'd0, 8'h00));
    send_item(make_item(FUNC_FINISH, KIND_SERVICE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h00));
    send_item(make_item(FUNC_START, KIND_SERVICE, 7'd127, 7'd127, 16'hFFFF, 11'd2047, 5'd31,
                        8'hFF));
    // Unknown kind on start and unknown function: dropped mid-frame, CRC untouched
    send_item(make_item(FUNC_START, KIND_RSVD, 7'd127, 7'd127, 16'hFFFF, 11'd2047, 5'd31,
                        8'hFF));
    send_item(make_item(FUNC_RSVD, KIND_RSVD, 7'd127, 7'd127, 16'hFFFF, 11'd2047, 5'd31,
                        8'hFF));
    send_item(make_item(FUNC_PAYLOAD, KIND_SERVICE, 7'd0, 7'd0, 16'd0, 11'd0, 5'd0, 8'h81));
    // Restart before finishing: the CRC starts over on the new header
    send_item(random_item(FUNC_START, KIND_MESSAGE));
    send_item(random_item(FUNC_FINISH, KIND_MESSAGE));
    wait_idle();

    // Random part over several sync settings, extremes first
    sync_plan[0] = 16'hFF00;
    sync_plan[1] = 16'h00FF;
    sync_plan[2] = 16'hFFFF;
    sync_plan[3] = 16'($urandom_range(0, 65535));
    sync_plan[4] = 16'($urandom_range(0, 65535));
    target = items_in;
    for (int p = 0; p < 5; p++) begin
      write_sync(CFG_SYNC_ONE, sync_plan[p][15:8]);
      write_sync(CFG_SYNC_TWO, sync_plan[p][7:0]);
      settings_used++;
      target += ITEMS_PER_PHASE;
      while (items_in < target) send_frame();
      no_idle = 1'b0;
      wait_idle();
    end

    if (board.due_q.size() != 0)
      board.report($sformatf("%0d bytes never sent", board.due_q.size()));
    $display("covered %0d command items over %0d sync settings", items_in, settings_used);
    $display("checked %0d line bytes, %0d frames closed with a CRC", board.bytes_checked,
             board.frames_closed);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
